FILE: hw/rtl/utf8d_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
// No dependencies; every other file of the decoder imports this package.
package utf8d_pkg;

   localparam int CP_W     = 21;
   localparam int USED_W   = 3;
   localparam int STATUS_W = 3;
   localparam int LEN_W    = 3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CP_W-1:0] REPL_CHAR      = 21'h00_FFFD;
   localparam logic [CP_W-1:0] SURROGATE_LO   = 21'h00_D800;
   localparam logic [CP_W-1:0] SURROGATE_HI   = 21'h00_DFFF;
   localparam logic [CP_W-1:0] MAX_SCALAR     = 21'h10_FFFF;
   localparam logic [CP_W-1:0] MIN_FOUR_BYTE  = 21'h01_0000;
   localparam logic [CP_W-1:0] MIN_THREE_BYTE = 21'h00_0800;
   localparam logic [CP_W-1:0] MIN_TWO_BYTE   = 21'h00_0080;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_LEAD   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_TRUNCATED  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_INCOMPLETE = 3'd4;

   localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
   localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
   localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

   typedef struct packed {
      logic [CP_W-1:0]     code_point;
      logic [USED_W-1:0]   bytes_used;
      logic [STATUS_W-1:0] status;
      logic                last_result;
   } result_type;

   // All results caused by one input byte: always a first, sometimes a second.
   typedef struct packed {
      logic       second_valid;
      result_type first;
      result_type second;
   } record_type;

   typedef struct packed {
      logic       valid;
      record_type rec;
   } push_type;

endpackage

FILE: hw/rtl/utf8d_if.sv
// Handshake channels of the UTF-8 stream decoder: byte requests and decoded results.
// Depends on utf8d_pkg for field widths.
interface utf8d_req_if
   import utf8d_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, text_byte, end_of_text, input ready);
   modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface utf8d_rsp_if
   import utf8d_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [CP_W-1:0]     code_point;
   logic [USED_W-1:0]   bytes_used;
   logic [STATUS_W-1:0] status;
   logic                last_result;

   modport source (output valid, code_point, bytes_used, status, last_result, input ready);
   modport sink   (input valid, code_point, bytes_used, status, last_result, output ready);
endinterface

FILE: hw/rtl/utf8_stream_decoder_unit.sv
// Streaming UTF-8 decoder: one text byte per request word, one code point per response word.
// A byte is accepted in every cycle while the two-record queue has room; a result is written
// into the queue and then into the output register, and one result leaves per cycle while the
// output port accepts, so a byte that yields two results (a cut-short sequence followed by a
// byte that yields a result on its own) sends both in turn; the output port sets the byte
// rate. Built from utf8d_front, utf8d_queue and utf8d_back; uses utf8d_pkg and utf8d_if.
module utf8_stream_decoder_unit
   import utf8d_pkg::*;
(
   input logic         clock,
   input logic         reset,
   utf8d_req_if.sink   req_bus,
   utf8d_rsp_if.source rsp_bus
);

   push_type   push;
   logic       space_ok;
   logic       head_valid;
   record_type head;
   logic       pop;
   result_type out_res;

   utf8d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_bus.valid),
      .text_byte   (req_bus.text_byte),
      .end_of_text (req_bus.end_of_text),
      .space_ok    (space_ok),
      .byte_ready  (req_bus.ready),
      .push        (push)
   );

   utf8d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .space_ok   (space_ok),
      .head_valid (head_valid),
      .head       (head)
   );

   utf8d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .out_ready  (rsp_bus.ready),
      .pop        (pop),
      .out_valid  (rsp_bus.valid),
      .out_res    (out_res)
   );

   assign rsp_bus.code_point  = out_res.code_point;
   assign rsp_bus.bytes_used  = out_res.bytes_used;
   assign rsp_bus.status      = out_res.status;
   assign rsp_bus.last_result = out_res.last_result;

endmodule

FILE: hw/rtl/utf8d_front.sv
// Front end of the decoder: holds the open sequence and classifies each byte.
// Produces one record of one or two results per byte that yields any. Uses utf8d_pkg.
module utf8d_front
   import utf8d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] text_byte,
   input  logic       end_of_text,
   input  logic       space_ok,
   output logic       byte_ready,
   output push_type   push
);

   logic [CP_W-1:0]  partial_ff,  partial_in;
   logic [LEN_W-1:0] exp_len_ff,  exp_len_in;
   logic [LEN_W-1:0] seen_ff,     seen_in;

   logic             fire;
   logic             is_cont;
   result_type       start_res;
   logic             start_has;
   logic             start_open;
   logic [LEN_W-1:0] start_len;
   logic [CP_W-1:0]  start_payload;
   logic [CP_W-1:0]  acc_value;
   logic [LEN_W-1:0] acc_seen;
   logic [CP_W-1:0]  min_value;
   logic             bad_value;
   logic             emit;

   assign byte_ready = space_ok;
   assign fire       = byte_valid && space_ok;
   assign is_cont    = (text_byte[7:6] == 2'b10);

   // Decoding of the byte as the start of a new sequence.
   always_comb begin
      start_res     = '{code_point: REPL_CHAR, bytes_used: USED_W'(1),
                        status: STATUS_BAD_LEAD, last_result: 1'b0};
      start_has     = 1'b1;
      start_open    = 1'b0;
      start_len     = LEN_NONE;
      start_payload = '0;
      priority if (text_byte[7] == 1'b0) begin
         start_res.code_point = {13'd0, text_byte};
         start_res.status     = STATUS_OK;
      end else if (text_byte[7:6] == 2'b10 || text_byte[7:3] == 5'b11111) begin
         start_res.status = STATUS_BAD_LEAD;
      end else begin
         priority if (text_byte[7:5] == 3'b110) begin
            start_len     = LEN_TWO;
            start_payload = {16'd0, text_byte[4:0]};
         end else if (text_byte[7:4] == 4'b1110) begin
            start_len     = LEN_THREE;
            start_payload = {17'd0, text_byte[3:0]};
         end else begin
            start_len     = LEN_FOUR;
            start_payload = {18'd0, text_byte[2:0]};
         end
         if (end_of_text) begin
            start_res.bytes_used = '0;
            start_res.status     = STATUS_INCOMPLETE;
         end else begin
            start_has  = 1'b0;
            start_open = 1'b1;
         end
      end
   end

   assign acc_value = {partial_ff[CP_W-7:0], text_byte[5:0]};
   assign acc_seen  = seen_ff + LEN_ONE;

   always_comb begin
      unique case (exp_len_ff)
         LEN_TWO:   min_value = MIN_TWO_BYTE;
         LEN_THREE: min_value = MIN_THREE_BYTE;
         default:   min_value = MIN_FOUR_BYTE;
      endcase
   end

   assign bad_value = (acc_value < min_value) || (acc_value > MAX_SCALAR) ||
                      (acc_value >= SURROGATE_LO && acc_value <= SURROGATE_HI);

   always_comb begin
      partial_in        = partial_ff;
      exp_len_in        = exp_len_ff;
      seen_in           = seen_ff;
      emit              = 1'b0;
      push.rec          = '0;
      push.rec.first    = start_res;
      push.rec.second   = start_res;
      if (exp_len_ff != LEN_NONE) begin
         if (is_cont) begin
            partial_in = acc_value;
            seen_in    = acc_seen;
            if (acc_seen >= exp_len_ff) begin
               emit                      = 1'b1;
               push.rec.first.bytes_used = exp_len_ff;
               push.rec.first.code_point = bad_value ? REPL_CHAR : acc_value;
               push.rec.first.status     = bad_value ? STATUS_RANGE : STATUS_OK;
               partial_in = '0;
               exp_len_in = LEN_NONE;
               seen_in    = LEN_NONE;
            end else if (end_of_text) begin
               emit                      = 1'b1;
               push.rec.first.code_point = REPL_CHAR;
               push.rec.first.bytes_used = '0;
               push.rec.first.status     = STATUS_INCOMPLETE;
               partial_in = '0;
               exp_len_in = LEN_NONE;
               seen_in    = LEN_NONE;
            end
         end else begin
            emit                      = 1'b1;
            push.rec.first.code_point = REPL_CHAR;
            push.rec.first.bytes_used = seen_ff;
            push.rec.first.status     = STATUS_TRUNCATED;
            push.rec.second_valid     = start_has;
            partial_in = start_open ? start_payload : '0;
            exp_len_in = start_open ? start_len : LEN_NONE;
            seen_in    = start_open ? LEN_ONE : LEN_NONE;
         end
      end else begin
         emit       = start_has;
         partial_in = start_open ? start_payload : '0;
         exp_len_in = start_open ? start_len : LEN_NONE;
         seen_in    = start_open ? LEN_ONE : LEN_NONE;
      end
      push.rec.first.last_result  = !push.rec.second_valid;
      push.rec.second.last_result = 1'b1;
      push.valid = fire && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         exp_len_ff <= LEN_NONE;
         seen_ff    <= LEN_NONE;
      end else if (fire) begin
         partial_ff <= partial_in;
         exp_len_ff <= exp_len_in;
         seen_ff    <= seen_in;
      end
   end

endmodule

FILE: hw/rtl/utf8d_queue.sv
// Short record queue between the decoder front end and the result serialiser.
// Flip-flop storage, registered occupancy. Uses utf8d_pkg.
module utf8d_queue
   import utf8d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       pop,
   output logic       space_ok,
   output logic       head_valid,
   output record_type head
);

   record_type             entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff,  count_in;
   logic                   do_pop;

   assign space_ok   = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push.valid, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.rec;
      end
   end

endmodule

FILE: hw/rtl/utf8d_back.sv
// Back end of the decoder: splits each queued record into single results.
// Drives the output register of the result channel. Uses utf8d_pkg.
module utf8d_back
   import utf8d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  record_type head,
   input  logic       out_ready,
   output logic       pop,
   output logic       out_valid,
   output result_type out_res
);

   logic       second_ff, second_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       load;

   assign load      = head_valid && (!out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;
   assign out_res   = out_ff;

   always_comb begin
      second_in    = second_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !out_ready;
      pop          = 1'b0;
      if (load) begin
         out_valid_in = 1'b1;
         out_in       = second_ff ? head.second : head.first;
         if (second_ff || !head.second_valid) begin
            pop       = 1'b1;
            second_in = 1'b0;
         end else begin
            second_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         second_ff    <= second_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule
